@@ rtl/core/fpba_pkg.sv @@
// shared types and constants for the fit-policy block allocator
// no dependencies; imported by every module of the allocator core
package fpba_pkg;

    // table geometry
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_BLOCKS);

    // placement policies; the unused code behaves as first fit
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_LOADED = 2'd0;
    localparam logic [1:0] STAT_ALLOC  = 2'd1;
    localparam logic [1:0] STAT_FAIL   = 2'd2;
    localparam logic [1:0] STAT_SKIP   = 2'd3;

    // search token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [IDX_W-1:0]     pick;
        logic [SIZE_BITS-1:0] best;
    } t_scan_pkt;

    // broadcast write into the table cells
    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] data;
    } t_cell_wr;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_ctl_state;

endpackage

@@ rtl/core/fpba_cell.sv @@
// one table cell: holds the free size of one block and updates the search token
// depends on fpba_pkg
module fpba_cell
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDX_W-1:0]     i_cell_idx,
    input  logic [1:0]           i_fit_mode,
    input  logic [COUNT_W-1:0]   i_block_count,
    input  logic [SIZE_BITS-1:0] i_req,
    input  t_cell_wr             i_wr,
    input  t_scan_pkt            i_pkt,
    output t_scan_pkt            o_pkt
);

    logic [SIZE_BITS-1:0] r_size;
    t_scan_pkt            r_pkt;
    t_scan_pkt            n_pkt;
    logic                 active;
    logic                 fits;
    logic                 take;

    // block is in use when its index lies below the count
    assign active = COUNT_W'(i_cell_idx) < i_block_count;
    assign fits   = i_req <= r_size;

    // policy decision against the token from the left neighbour
    always_comb begin
        case (i_fit_mode)
            FIT_BEST:  take = active && fits && (!i_pkt.found || r_size < i_pkt.best);
            FIT_WORST: take = active && (!i_pkt.found || r_size > i_pkt.best);
            default:   take = active && fits && !i_pkt.found;
        endcase
    end

    always_comb begin
        n_pkt = i_pkt;
        if (take) begin
            n_pkt.found = 1'b1;
            n_pkt.best  = r_size;
            n_pkt.pick  = i_cell_idx;
        end
    end

    // token register towards the right neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.valid <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    // stored free size, written by load or write-back
    always_ff @(posedge i_clk) begin
        if (i_wr.we && (i_wr.idx == i_cell_idx)) begin
            r_size <= i_wr.data;
        end
    end

    assign o_pkt = r_pkt;

endmodule

@@ rtl/core/fpba_ctrl.sv @@
// command sequencer: accepts items, launches the search, writes back and
// holds the result register; depends on fpba_pkg
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [SIZE_BITS-1:0] i_size_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [IDX_W-1:0]     o_chosen_block,
    output logic [SIZE_BITS-1:0] o_size_before,
    output logic [SIZE_BITS-1:0] o_size_left,
    output t_scan_pkt            o_start_pkt,
    input  t_scan_pkt            i_end_pkt,
    output t_cell_wr             o_wr,
    output logic [SIZE_BITS-1:0] o_req
);

    t_ctl_state           r_state;
    t_ctl_state           n_state;
    logic                 r_halted;
    logic                 n_halted;
    logic                 r_start;
    logic                 n_start;
    logic [SIZE_BITS-1:0] r_req;
    logic [1:0]           r_res_status;
    logic [1:0]           n_res_status;
    logic [IDX_W-1:0]     r_res_blk;
    logic [IDX_W-1:0]     n_res_blk;
    logic [SIZE_BITS-1:0] r_res_before;
    logic [SIZE_BITS-1:0] n_res_before;
    logic [SIZE_BITS-1:0] r_res_left;
    logic [SIZE_BITS-1:0] n_res_left;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [IDX_W-1:0]     r_out_blk;
    logic [SIZE_BITS-1:0] r_out_before;
    logic [SIZE_BITS-1:0] r_out_left;
    logic                 acc;
    logic                 out_free;
    logic                 found_f;
    logic [SIZE_BITS-1:0] remain;

    assign acc      = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // worst fit carries only a candidate, so the size check is repeated here
    assign found_f = i_end_pkt.found && (r_req <= i_end_pkt.best);
    assign remain  = i_end_pkt.best - r_req;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_command == CMD_ALLOC && !r_halted) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (i_end_pkt.valid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs: table write, halted flag, pending result
    always_comb begin
        o_wr         = '0;
        n_halted     = r_halted;
        n_start      = 1'b0;
        n_res_status = r_res_status;
        n_res_blk    = r_res_blk;
        n_res_before = r_res_before;
        n_res_left   = r_res_left;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_res_blk    = '0;
                    n_res_before = '0;
                    n_res_left   = '0;
                    if (i_command == CMD_LOAD) begin
                        o_wr.we      = 1'b1;
                        o_wr.idx     = i_block_index;
                        o_wr.data    = i_size_value;
                        n_halted     = 1'b0;
                        n_res_status = STAT_LOADED;
                    end else if (r_halted) begin
                        n_res_status = STAT_SKIP;
                    end else begin
                        n_start = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (i_end_pkt.valid) begin
                    if (found_f) begin
                        o_wr.we      = 1'b1;
                        o_wr.idx     = i_end_pkt.pick;
                        o_wr.data    = remain;
                        n_res_status = STAT_ALLOC;
                        n_res_blk    = i_end_pkt.pick;
                        n_res_before = i_end_pkt.best;
                        n_res_left   = remain;
                    end else begin
                        n_halted     = 1'b1;
                        n_res_status = STAT_FAIL;
                        n_res_blk    = '0;
                        n_res_before = '0;
                        n_res_left   = '0;
                    end
                end
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_halted <= 1'b0;
            r_start  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_halted <= n_halted;
            r_start  <= n_start;
        end
    end

    // request size and pending result
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req <= i_size_value;
        end
        r_res_status <= n_res_status;
        r_res_blk    <= n_res_blk;
        r_res_before <= n_res_before;
        r_res_left   <= n_res_left;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out_status <= r_res_status;
            r_out_blk    <= r_res_blk;
            r_out_before <= r_res_before;
            r_out_left   <= r_res_left;
        end
    end

    // token launched into the first cell
    always_comb begin
        o_start_pkt       = '0;
        o_start_pkt.valid = r_start;
    end

    assign o_req          = r_req;
    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_chosen_block = r_out_blk;
    assign o_size_before  = r_out_before;
    assign o_size_left    = r_out_left;

`ifndef ASSERT_OFF
    // a token only leaves the chain while a search is under way
    a_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end_pkt.valid |-> (r_state == ST_SCAN))
        else $error("search token left the chain outside a scan");

    // a launched token always belongs to a scan
    a_start_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == ST_SCAN))
        else $error("search launched outside a scan");

    // the table is never written while a result waits
    a_no_write_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.we |-> (r_state != ST_FINISH))
        else $error("table write while result pending");

    // halting only follows a completed scan
    a_halt_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halted) |-> $past(r_state == ST_SCAN))
        else $error("halted set without a failed scan");
`endif

endmodule

@@ rtl/core/fit_policy_block_allocator_core.sv @@
// top level of the fit-policy block allocator: configuration registers,
// chain of table cells and command sequencer; depends on fpba_pkg, fpba_cell, fpba_ctrl

// The block keeps the free sizes of MAX_BLOCKS blocks, one per cell in a chain.
// A load writes its table entry as it is taken; an allocation is carried by a
// search token that walks the chain one cell per clock (through the MAX_BLOCKS
// cells from the transfer, then a write-back, a move of the result into the
// output register once it is free and a return to idle before the next
// transfer). One item is in flight at a time; the result register lets the next
// item be taken while the previous result still waits. Table entries are not
// cleared by reset and must be loaded before an allocation reads them.
// Registers: fit_mode at 0x0 (0 first, 1 best, 2 worst fit, 3 as first fit) and
// block_count at 0x4; write them only while the block is idle.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    // command channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [SIZE_BITS-1:0] i_size_value,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [IDX_W-1:0]     o_chosen_block,
    output logic [SIZE_BITS-1:0] o_size_before,
    output logic [SIZE_BITS-1:0] o_size_left
);

    logic [1:0]           r_fit_mode;
    logic [COUNT_W-1:0]   r_block_count;
    logic                 cfg_wr;
    logic [SIZE_BITS-1:0] req;
    t_cell_wr             cell_wr;
    t_scan_pkt            chain_pkt [MAX_BLOCKS+1];

    // register writes complete in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FIT_MODE:    r_fit_mode    <= pwdata[1:0];
                REG_BLOCK_COUNT: r_block_count <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_FIT_MODE:    prdata = DATA_W'(r_fit_mode);
            REG_BLOCK_COUNT: prdata = DATA_W'(r_block_count);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    fpba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_block_index  (i_block_index),
        .i_size_value   (i_size_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_chosen_block (o_chosen_block),
        .o_size_before  (o_size_before),
        .o_size_left    (o_size_left),
        .o_start_pkt    (chain_pkt[0]),
        .i_end_pkt      (chain_pkt[MAX_BLOCKS]),
        .o_wr           (cell_wr),
        .o_req          (req)
    );

    // chain of table cells, token flows from index 0 upwards
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        fpba_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cell_idx    (IDX_W'(g)),
            .i_fit_mode    (r_fit_mode),
            .i_block_count (r_block_count),
            .i_req         (req),
            .i_wr          (cell_wr),
            .i_pkt         (chain_pkt[g]),
            .o_pkt         (chain_pkt[g+1])
        );
    end

endmodule

@@ dv/fit_policy_block_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for fit_policy_block_allocator_core: directed and random
// load/allocate traffic checked against an in-bench placement predictor
// depends on fpba_pkg and the allocator core rtl
module fit_policy_block_allocator_core_tb;
    import fpba_pkg::*;

    // the spare policy code, which the block treats as first fit
    localparam logic [1:0] FIT_AS_FIRST = 2'd3;

    localparam logic [ADDR_W-1:0] FIT_MODE_ADDR    = ADDR_W'(4 * int'(REG_FIT_MODE));
    localparam logic [ADDR_W-1:0] BLOCK_COUNT_ADDR = ADDR_W'(4 * int'(REG_BLOCK_COUNT));

    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic                 command;
        logic [IDX_W-1:0]     blk;
        logic [SIZE_BITS-1:0] size_val;
    } alloc_cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_W-1:0]     blk;
        logic [SIZE_BITS-1:0] prior;
        logic [SIZE_BITS-1:0] remain;
    } grant_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_command = CMD_LOAD;
    logic [IDX_W-1:0]     i_block_index = '0;
    logic [SIZE_BITS-1:0] i_size_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_status;
    logic [IDX_W-1:0]     o_chosen_block;
    logic [SIZE_BITS-1:0] o_size_before;
    logic [SIZE_BITS-1:0] o_size_left;

    // predictor state: free sizes, halt flag and register copies
    logic [SIZE_BITS-1:0] free_shadow [MAX_BLOCKS];
    logic                 halt_shadow = 1'b0;
    logic [1:0]           mode_shadow = FIT_FIRST;
    logic [4:0]           count_shadow = 5'(MAX_BLOCKS);

    alloc_cmd_t pending_cmds [$];
    grant_t     expected_grants [$];
    alloc_cmd_t on_port;
    int         gap_left = 0;
    bit         tx_burst = 1'b0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         hold_at = 300;
    bit         rx_burst = 1'b0;
    int         n_grants = 0;
    int         mismatches = 0;

    fit_policy_block_allocator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_block_index  (i_block_index),
        .i_size_value   (i_size_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_chosen_block (o_chosen_block),
        .o_size_before  (o_size_before),
        .o_size_left    (o_size_left)
    );

    always #2 i_clk = ~i_clk;

    // placement predictor: applies one command to the shadow table
    function automatic grant_t predict_grant(input alloc_cmd_t c);
        grant_t               g;
        int                   n;
        int                   j;
        logic                 found;
        logic [IDX_W-1:0]     pick;
        logic [SIZE_BITS-1:0] best;
        g = '0;
        found = 1'b0;
        pick = '0;
        best = '0;
        if (c.command == CMD_LOAD) begin
            free_shadow[c.blk] = c.size_val;
            halt_shadow = 1'b0;
            g.status = STAT_LOADED;
            return g;
        end
        if (halt_shadow) begin
            g.status = STAT_SKIP;
            return g;
        end
        n = (count_shadow > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_shadow);
        case (mode_shadow)
            FIT_BEST: begin
                for (j = 0; j < n; j++) begin
                    if (c.size_val <= free_shadow[j] && (!found || free_shadow[j] < best)) begin
                        found = 1'b1;
                        best = free_shadow[j];
                        pick = IDX_W'(j);
                    end
                end
            end
            FIT_WORST: begin
                if (n > 0) begin
                    best = free_shadow[0];
                    for (j = 1; j < n; j++) begin
                        if (free_shadow[j] > best) begin
                            best = free_shadow[j];
                            pick = IDX_W'(j);
                        end
                    end
                    found = (c.size_val <= best);
                end
            end
            default: begin
                for (j = 0; j < n; j++) begin
                    if (!found && c.size_val <= free_shadow[j]) begin
                        found = 1'b1;
                        best = free_shadow[j];
                        pick = IDX_W'(j);
                    end
                end
            end
        endcase
        if (!found) begin
            halt_shadow = 1'b1;
            g.status = STAT_FAIL;
            return g;
        end
        free_shadow[pick] = best - c.size_val;
        g.status = STAT_ALLOC;
        g.blk = pick;
        g.prior = best;
        g.remain = free_shadow[pick];
        return g;
    endfunction

    task automatic offer_next();
        on_port = pending_cmds.pop_front();
        i_command <= on_port.command;
        i_block_index <= on_port.blk;
        i_size_value <= on_port.size_val;
        i_valid <= 1'b1;
    endtask

    // command driver with random gaps between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else if (i_valid && !o_stall) begin
            expected_grants.push_back(predict_grant(on_port));
            if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
            gap_left = tx_burst ? 0 : int'($urandom_range(0, 5));
            if (gap_left == 0 && pending_cmds.size() != 0) begin
                offer_next();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_cmds.size() != 0) begin
                offer_next();
            end
        end
    end

    // result back-pressure: short random stalls plus an occasional long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= (hold_left != 0);
        end else if (n_grants >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at = hold_at + 700;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
            stall_left = rx_burst ? 0 : int'($urandom_range(0, 5));
            i_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    task automatic note_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // result monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        grant_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_grants <= n_grants + 1;
            if (expected_grants.size() == 0) begin
                note_mismatch("unexpected result, status", int'(o_status), -1);
            end else begin
                want = expected_grants.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", int'(o_status), int'(want.status));
                if (o_chosen_block !== want.blk)
                    note_mismatch("chosen_block", int'(o_chosen_block), int'(want.blk));
                if (o_size_before !== want.prior)
                    note_mismatch("size_before", int'(o_size_before), int'(want.prior));
                if (o_size_left !== want.remain)
                    note_mismatch("size_left", int'(o_size_left), int'(want.remain));
            end
        end
    end

    task automatic push_load(input int unsigned idx, input int unsigned sz);
        pending_cmds.push_back('{CMD_LOAD, IDX_W'(idx), SIZE_BITS'(sz)});
    endtask

    task automatic push_alloc(input int unsigned sz);
        pending_cmds.push_back('{CMD_ALLOC, IDX_W'($urandom_range(0, MAX_BLOCKS - 1)),
                                 SIZE_BITS'(sz)});
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_valid || expected_grants.size() != 0);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == FIT_MODE_ADDR) mode_shadow = data[1:0];
        else count_shadow = data[4:0];
    endtask

    // registers change only once the previous phase has fully drained
    task automatic set_config(input logic [1:0] mode, input int unsigned count);
        wait_idle();
        cfg_write(FIT_MODE_ADDR, DATA_W'(mode));
        cfg_write(BLOCK_COUNT_ADDR, DATA_W'(count));
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned seed_sizes [MAX_BLOCKS] = '{0, 65535, 100, 50, 300, 100, 21845, 40,
                                                 60, 80, 120, 140, 160, 180, 200, 43690};
        logic [1:0]  ph_mode [8] = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_AS_FIRST,
                                     FIT_WORST, FIT_BEST, FIT_FIRST, FIT_WORST};
        int unsigned ph_count [8] = '{16, 1, 9, 16, 31, 0, 16, 4};
        int unsigned n_items;
        int unsigned roll;
        int unsigned sz;
        int          p;
        int          k;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every block loaded before any allocation, with both bit patterns
        for (k = 0; k < MAX_BLOCKS; k++) push_load(k, seed_sizes[k]);
        // first fit at reset settings: zero request, full-size request, plain fit
        push_alloc(0);
        push_alloc(65535);
        push_alloc(60);
        // nothing fits, then a skipped request, then a load clears the halt
        push_alloc(65535);
        push_alloc(1);
        push_load(1, 1000);
        push_alloc(500);

        // best fit with an exact match and a near match
        set_config(FIT_BEST, 16);
        push_alloc(40);
        push_alloc(45);

        // worst fit over one empty block with a zero request, then failure, a skip and a load
        set_config(FIT_WORST, 1);
        push_alloc(0);
        push_alloc(1);
        push_alloc(1);
        push_load(5, 777);

        // spare policy code with no blocks in use
        set_config(FIT_AS_FIRST, 0);
        push_alloc(0);
        push_load(0, 5);

        // block count past the table size
        set_config(FIT_WORST, 31);
        push_alloc(700);

        // random phases: mostly allocations with occasional reloads
        for (p = 0; p < 8; p++) begin
            set_config(ph_mode[p], ph_count[p]);
            n_items = (ph_count[p] == 0) ? 40 : 250;
            for (k = 0; k < n_items; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 25) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60) sz = $urandom_range(0, 2000);
                    else if (roll < 85) sz = $urandom_range(0, 65535);
                    else if (roll < 95) sz = 0;
                    else sz = 65535;
                    push_load($urandom_range(0, MAX_BLOCKS - 1), sz);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 50) sz = $urandom_range(0, 300);
                    else if (roll < 75) sz = $urandom_range(0, 3000);
                    else if (roll < 90) sz = $urandom_range(0, 65535);
                    else sz = 0;
                    push_alloc(sz);
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fit_policy_block_allocator_core_tb: done, clean");
        end else begin
            $display("fit_policy_block_allocator_core_tb: done, errors");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #2000000;
        $display("fit_policy_block_allocator_core_tb: done, errors");
        $finish;
    end

endmodule
